>>> src/scoped_symbol_table_top_defines.svh
// Assertion macros, sampled on clock and disabled while reset is high.
`ifndef SCOPED_SYMBOL_TABLE_TOP_DEFINES_SVH
`define SCOPED_SYMBOL_TABLE_TOP_DEFINES_SVH

// Consequent holds in the same cycle.
`define SSYM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent holds in the next cycle.
`define SSYM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/ssym_pkg.sv
package ssym_pkg;

   localparam int NAME_W         = 128;
   localparam int NAME_BYTES_MAX = 16;
   localparam int DTYPE_W        = 4;
   localparam int SCOPE_OUT_W    = 4;
   localparam int SLOT_OUT_W     = 7;

   typedef enum logic [1:0] {
      REQ_PUSH,
      REQ_POP,
      REQ_FIND,
      REQ_ADD
   } req_kind_type;

   typedef enum logic [2:0] {
      STAT_OK,
      STAT_NOT_FOUND,
      STAT_REDECLARED,
      STAT_FULL,
      STAT_OVERFLOW,
      STAT_UNDERFLOW
   } status_type;

   typedef struct packed {
      logic                   found;
      logic [SCOPE_OUT_W-1:0] scope;
      logic [SLOT_OUT_W-1:0]  slot;
      logic [DTYPE_W-1:0]     dtype;
   } hit_info_type;

endpackage

>>> src/ssym_ram.sv
module ssym_ram #(
   parameter int DEPTH  = 256,
   parameter int WIDTH  = 136,
   parameter int ADDR_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> src/ssym_scan.sv
module ssym_scan import ssym_pkg::*; #(
   parameter int ADDR_W = 8,
   parameter int DEP_W  = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            clear,
   input  logic                            rd_vld,
   input  logic [ADDR_W-1:0]               rd_idx,
   input  logic [NAME_W+DTYPE_W+DEP_W-1:0] rd_entry,
   input  logic [NAME_W-1:0]               key,
   output hit_info_type                    hit
);

   logic [NAME_W-1:0]  rd_name;
   logic [DTYPE_W-1:0] rd_type;
   logic [DEP_W-1:0]   rd_scope;
   logic [ADDR_W-1:0]  base_now;
   logic               take;

   logic               first_ff, first_in;
   logic               hit_ff, hit_in;
   logic [DEP_W-1:0]   prev_scope_ff, prev_scope_in;
   logic [ADDR_W-1:0]  base_ff, base_in;
   logic [DEP_W-1:0]   hit_scope_ff, hit_scope_in;
   logic [ADDR_W-1:0]  hit_slot_ff, hit_slot_in;
   logic [DTYPE_W-1:0] hit_type_ff, hit_type_in;

   assign rd_name  = rd_entry[NAME_W+DTYPE_W+DEP_W-1 -: NAME_W];
   assign rd_type  = rd_entry[DTYPE_W+DEP_W-1 -: DTYPE_W];
   assign rd_scope = rd_entry[DEP_W-1:0];

   // entries are ordered by scope; the first index of a scope run is its base
   assign base_now = (first_ff || rd_scope != prev_scope_ff) ? rd_idx : base_ff;
   // keep first match within a scope, prefer later (inner) scopes
   assign take = (rd_name == key) && (!hit_ff || rd_scope != hit_scope_ff);

   always_comb begin
      first_in      = first_ff;
      hit_in        = hit_ff;
      prev_scope_in = prev_scope_ff;
      base_in       = base_ff;
      hit_scope_in  = hit_scope_ff;
      hit_slot_in   = hit_slot_ff;
      hit_type_in   = hit_type_ff;
      if (clear) begin
         first_in = 1'b1;
         hit_in   = 1'b0;
      end else if (rd_vld) begin
         first_in      = 1'b0;
         prev_scope_in = rd_scope;
         base_in       = base_now;
         if (take) begin
            hit_in       = 1'b1;
            hit_scope_in = rd_scope;
            hit_slot_in  = rd_idx - base_now;
            hit_type_in  = rd_type;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
         hit_ff   <= 1'b0;
      end else begin
         first_ff <= first_in;
         hit_ff   <= hit_in;
      end
      prev_scope_ff <= prev_scope_in;
      base_ff       <= base_in;
      hit_scope_ff  <= hit_scope_in;
      hit_slot_ff   <= hit_slot_in;
      hit_type_ff   <= hit_type_in;
   end

   assign hit.found = hit_ff;
   assign hit.scope = SCOPE_OUT_W'(hit_scope_ff);
   assign hit.slot  = SLOT_OUT_W'(hit_slot_ff);
   assign hit.dtype = hit_type_ff;

endmodule

>>> src/scoped_symbol_table_top.sv
// Channel   Ports                                   Transfer
// request   start, busy, req_*                      start high while busy low
// response  rsp_valid, rsp_*                        one cycle strobe, always taken
//
// Push and pop: the taken word goes to S_FINISH, which registers the strobe.
// Find: S_SCAN reads every entry, one entry read per cycle, then S_FINISH registers the strobe.
// Add: same, scanning only the current scope's run of entries.
// busy stays high from the accepted word until the strobe cycle.
// Synchronous reset empties the table at once; entry RAM contents are not cleared.
// The receiver cannot stall a response word.
`include "scoped_symbol_table_top_defines.svh"

module scoped_symbol_table_top import ssym_pkg::*; #(
   parameter int ENTRIES_PER_SCOPE = 128,
   parameter int NAME_BYTES        = 16,
   parameter int MAX_SCOPES        = 16,
   parameter int TOTAL_ENTRIES     = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_type,
   input  logic [63:0]            req_name_lo,
   input  logic [63:0]            req_name_hi,
   input  logic [DTYPE_W-1:0]     req_data_type,
   output logic                   rsp_valid,
   output logic [2:0]             rsp_status,
   output logic [SCOPE_OUT_W-1:0] rsp_found_scope,
   output logic [SLOT_OUT_W-1:0]  rsp_found_slot,
   output logic [DTYPE_W-1:0]     rsp_found_type
);

   localparam int CNT_W  = $clog2(TOTAL_ENTRIES + 1);
   localparam int ADDR_W = (TOTAL_ENTRIES > 1) ? $clog2(TOTAL_ENTRIES) : 1;
   localparam int DEP_W  = (MAX_SCOPES > 1) ? $clog2(MAX_SCOPES) : 1;
   localparam int ENT_W  = NAME_W + DTYPE_W + DEP_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

   state_type              state_ff, state_in;
   req_kind_type           req_ff, req_in;
   logic [NAME_W-1:0]      key_ff, key_in;
   logic [DTYPE_W-1:0]     dtype_ff, dtype_in;
   logic [DEP_W-1:0]       depth_ff, depth_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       starts_ff [MAX_SCOPES];
   logic [CNT_W-1:0]       starts_in [MAX_SCOPES];
   logic [CNT_W-1:0]       scan_ff, scan_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic [ADDR_W-1:0]      rd_idx_ff, rd_idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [SCOPE_OUT_W-1:0] rsp_scope_ff, rsp_scope_in;
   logic [SLOT_OUT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic [DTYPE_W-1:0]     rsp_type_ff, rsp_type_in;

   logic [NAME_W-1:0]      name_raw;
   logic [NAME_W-1:0]      name_norm;
   logic                   keep;
   logic [CNT_W-1:0]       start_cur;
   logic [CNT_W-1:0]       used_cur;
   logic                   accept;
   logic                   issue;
   logic                   ram_wr;
   logic [ENT_W-1:0]       rd_entry;
   hit_info_type           hit;

   assign name_raw  = {req_name_hi, req_name_lo};
   assign accept    = start && state_ff == S_IDLE;
   assign start_cur = starts_ff[depth_ff];
   assign used_cur  = count_ff - start_cur;
   assign issue     = state_ff == S_SCAN && scan_ff < count_ff;

   // bytes after the first zero, or past NAME_BYTES, are dropped
   always_comb begin
      keep = 1'b1;
      for (int i = 0; i < NAME_BYTES_MAX; i++) begin
         keep = keep && (name_raw[8*i +: 8] != 8'd0) && (i < NAME_BYTES);
         name_norm[8*i +: 8] = keep ? name_raw[8*i +: 8] : 8'd0;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      key_in        = key_ff;
      dtype_in      = dtype_ff;
      depth_in      = depth_ff;
      count_in      = count_ff;
      starts_in     = starts_ff;
      scan_in       = scan_ff;
      rd_vld_in     = issue;
      rd_idx_in     = scan_ff[ADDR_W-1:0];
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_scope_in  = rsp_scope_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_type_in   = rsp_type_ff;
      ram_wr        = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_kind_type'(req_type);
               key_in   = name_norm;
               dtype_in = req_data_type;
               case (req_kind_type'(req_type))
                  REQ_FIND: begin
                     scan_in  = '0;
                     state_in = S_SCAN;
                  end
                  REQ_ADD: begin
                     scan_in  = start_cur;
                     state_in = S_SCAN;
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (issue) begin
               scan_in = scan_ff + 1'b1;
            end else if (!rd_vld_ff) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            state_in      = S_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_status_in = STAT_OK;
            rsp_scope_in  = '0;
            rsp_slot_in   = '0;
            rsp_type_in   = '0;
            case (req_ff)
               REQ_PUSH: begin
                  if (int'(depth_ff) + 1 >= MAX_SCOPES) begin
                     rsp_status_in = STAT_OVERFLOW;
                     rsp_scope_in  = SCOPE_OUT_W'(depth_ff);
                  end else begin
                     depth_in                = depth_ff + 1'b1;
                     starts_in[depth_in]     = count_ff;
                     rsp_scope_in            = SCOPE_OUT_W'(depth_in);
                  end
               end
               REQ_POP: begin
                  if (depth_ff == '0) begin
                     rsp_status_in = STAT_UNDERFLOW;
                  end else begin
                     count_in     = start_cur;
                     depth_in     = depth_ff - 1'b1;
                     rsp_scope_in = SCOPE_OUT_W'(depth_in);
                  end
               end
               REQ_FIND: begin
                  if (hit.found) begin
                     rsp_scope_in = hit.scope;
                     rsp_slot_in  = hit.slot;
                     rsp_type_in  = hit.dtype;
                  end else begin
                     rsp_status_in = STAT_NOT_FOUND;
                  end
               end
               REQ_ADD: begin
                  if (hit.found) begin
                     rsp_status_in = STAT_REDECLARED;
                     rsp_scope_in  = hit.scope;
                     rsp_slot_in   = hit.slot;
                     rsp_type_in   = hit.dtype;
                  end else if (int'(count_ff) >= TOTAL_ENTRIES ||
                               int'(used_cur) >= ENTRIES_PER_SCOPE) begin
                     rsp_status_in = STAT_FULL;
                  end else begin
                     ram_wr       = 1'b1;
                     count_in     = count_ff + 1'b1;
                     rsp_scope_in = SCOPE_OUT_W'(depth_ff);
                     rsp_slot_in  = SLOT_OUT_W'(used_cur);
                     rsp_type_in  = dtype_ff;
                  end
               end
               default: begin
                  rsp_status_in = STAT_OK;
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         depth_ff     <= '0;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_SCOPES; i++) begin
            starts_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         count_ff     <= count_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         starts_ff    <= starts_in;
      end
      req_ff        <= req_in;
      key_ff        <= key_in;
      dtype_ff      <= dtype_in;
      scan_ff       <= scan_in;
      rd_idx_ff     <= rd_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_scope_ff  <= rsp_scope_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_type_ff   <= rsp_type_in;
   end

   ssym_ram #(
      .DEPTH  (TOTAL_ENTRIES),
      .WIDTH  (ENT_W),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data ({key_ff, dtype_ff, depth_ff}),
      .rd_en   (issue),
      .rd_addr (scan_ff[ADDR_W-1:0]),
      .rd_data (rd_entry)
   );

   ssym_scan #(
      .ADDR_W (ADDR_W),
      .DEP_W  (DEP_W)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .clear    (accept),
      .rd_vld   (rd_vld_ff),
      .rd_idx   (rd_idx_ff),
      .rd_entry (rd_entry),
      .key      (key_ff),
      .hit      (hit)
   );

   assign busy            = state_ff != S_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_scope = rsp_scope_ff;
   assign rsp_found_slot  = rsp_slot_ff;
   assign rsp_found_type  = rsp_type_ff;

   `SSYM_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
   `SSYM_ASSERT_NOW(a_rsp_idle, rsp_valid, !busy, "response strobe while busy")
   `SSYM_ASSERT_NEXT(a_rsp_pulse, rsp_valid, !rsp_valid, "response strobe held two cycles")
   `SSYM_ASSERT_NOW(a_count_cap, 1'b1, int'(count_ff) <= TOTAL_ENTRIES, "entry count past capacity")
   `SSYM_ASSERT_NOW(a_read_in_scan, rd_vld_ff, state_ff == S_SCAN, "entry read outside scan")

endmodule

>>> tb/scoped_symbol_table_top_test.sv
`timescale 1ns / 100ps

module scoped_symbol_table_top_test;
   import ssym_pkg::*;

   localparam int SCOPE_CAP  = 128;
   localparam int NAME_LEN   = 16;
   localparam int SCOPE_LIMIT = 16;
   localparam int STORE_CAP  = 256;

   typedef struct packed {
      status_type             status;
      logic [SCOPE_OUT_W-1:0] scope;
      logic [SLOT_OUT_W-1:0]  slot;
      logic [DTYPE_W-1:0]     dtype;
   } lookup_result_type;

   typedef struct {
      req_kind_type        kind;
      logic [63:0]         lo;
      logic [63:0]         hi;
      logic [DTYPE_W-1:0]  dt;
      int                  reps;
      bit                  typed;
      lookup_result_type   want;
   } script_row_type;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [1:0]             req_type;
   logic [63:0]            req_name_lo;
   logic [63:0]            req_name_hi;
   logic [DTYPE_W-1:0]     req_data_type;
   logic                   rsp_valid;
   logic [2:0]             rsp_status;
   logic [SCOPE_OUT_W-1:0] rsp_found_scope;
   logic [SLOT_OUT_W-1:0]  rsp_found_slot;
   logic [DTYPE_W-1:0]     rsp_found_type;

   // predictor state
   logic [NAME_W-1:0]  sym_name  [STORE_CAP];
   logic [DTYPE_W-1:0] sym_type  [STORE_CAP];
   logic [3:0]         sym_scope [STORE_CAP];
   int                 scope_base [SCOPE_LIMIT];
   int                 sym_count;
   int                 cur_depth;

   lookup_result_type expected_q[$];
   script_row_type    script[$];
   int                fail_count;
   bit                steady;

   scoped_symbol_table_top #(
      .ENTRIES_PER_SCOPE (SCOPE_CAP),
      .NAME_BYTES        (NAME_LEN),
      .MAX_SCOPES        (SCOPE_LIMIT),
      .TOTAL_ENTRIES     (STORE_CAP)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_name_lo     (req_name_lo),
      .req_name_hi     (req_name_hi),
      .req_data_type   (req_data_type),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_found_scope (rsp_found_scope),
      .rsp_found_slot  (rsp_found_slot),
      .rsp_found_type  (rsp_found_type)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [NAME_W-1:0] trim_name(logic [63:0] lo, logic [63:0] hi);
      logic [NAME_W-1:0] raw;
      logic [NAME_W-1:0] res;
      bit                ended;
      raw   = {hi, lo};
      res   = '0;
      ended = 1'b0;
      for (int i = 0; i < 16; i++) begin
         if (i >= NAME_LEN || raw[i*8 +: 8] == 8'h00) ended = 1'b1;
         if (!ended) res[i*8 +: 8] = raw[i*8 +: 8];
      end
      return res;
   endfunction

   // entry index of key in scope d, or -1
   function automatic int scan_scope(int d, logic [NAME_W-1:0] key);
      int first;
      int last;
      first = scope_base[d];
      last  = (d >= cur_depth) ? sym_count : scope_base[d+1];
      for (int i = first; i < last; i++)
         if (sym_name[i] == key) return i;
      return -1;
   endfunction

   function automatic lookup_result_type describe_entry(status_type st, int idx);
      lookup_result_type res;
      int                d;
      d          = sym_scope[idx];
      res.status = st;
      res.scope  = sym_scope[idx];
      res.slot   = SLOT_OUT_W'(idx - scope_base[d]);
      res.dtype  = sym_type[idx];
      return res;
   endfunction

   function automatic lookup_result_type resolve_request(req_kind_type kind, logic [63:0] lo,
                                                         logic [63:0] hi,
                                                         logic [DTYPE_W-1:0] dt);
      lookup_result_type res;
      logic [NAME_W-1:0] key;
      int                hit;
      int                d;
      res = '0;
      key = trim_name(lo, hi);
      case (kind)
         REQ_PUSH: begin
            if (cur_depth + 1 >= SCOPE_LIMIT) begin
               res.status = STAT_OVERFLOW;
            end else begin
               cur_depth++;
               scope_base[cur_depth] = sym_count;
               res.status = STAT_OK;
            end
            res.scope = SCOPE_OUT_W'(cur_depth);
         end
         REQ_POP: begin
            if (cur_depth == 0) begin
               res.status = STAT_UNDERFLOW;
            end else begin
               sym_count = scope_base[cur_depth];
               cur_depth--;
               res.status = STAT_OK;
            end
            res.scope = SCOPE_OUT_W'(cur_depth);
         end
         REQ_FIND: begin
            res.status = STAT_NOT_FOUND;
            hit = -1;
            for (d = cur_depth; d >= 0 && hit < 0; d--) begin
               hit = scan_scope(d, key);
               if (hit >= 0) res = describe_entry(STAT_OK, hit);
            end
         end
         default: begin
            hit = scan_scope(cur_depth, key);
            if (hit >= 0) begin
               res = describe_entry(STAT_REDECLARED, hit);
            end else if (sym_count >= STORE_CAP ||
                         sym_count - scope_base[cur_depth] >= SCOPE_CAP) begin
               res.status = STAT_FULL;
            end else begin
               sym_name[sym_count]  = key;
               sym_type[sym_count]  = dt;
               sym_scope[sym_count] = 4'(cur_depth);
               sym_count++;
               res = describe_entry(STAT_OK, sym_count - 1);
            end
         end
      endcase
      return res;
   endfunction

   function automatic logic [NAME_W-1:0] random_name(int len);
      logic [NAME_W-1:0] res;
      res = '0;
      for (int i = 0; i < len; i++) res[i*8 +: 8] = 8'($urandom_range(1, 255));
      return res;
   endfunction

   task automatic row(req_kind_type kind, logic [63:0] lo, logic [63:0] hi,
                      logic [DTYPE_W-1:0] dt, int reps, bit typed, status_type st,
                      int sc, int sl, int ty);
      script_row_type r;
      r.kind         = kind;
      r.lo           = lo;
      r.hi           = hi;
      r.dt           = dt;
      r.reps         = reps;
      r.typed        = typed;
      r.want.status  = st;
      r.want.scope   = SCOPE_OUT_W'(sc);
      r.want.slot    = SLOT_OUT_W'(sl);
      r.want.dtype   = DTYPE_W'(ty);
      script.push_back(r);
   endtask

   task automatic send_word(req_kind_type kind, logic [63:0] lo, logic [63:0] hi,
                            logic [DTYPE_W-1:0] dt, bit typed, lookup_result_type want);
      lookup_result_type model;
      int                gap;
      @(negedge clock);
      gap = (!steady && $urandom_range(0, 99) < 24) ? $urandom_range(1, 6) : 0;
      while (gap > 0) begin
         start = 1'b0;
         gap--;
         @(negedge clock);
      end
      start         = 1'b1;
      req_type      = kind;
      req_name_lo   = lo;
      req_name_hi   = hi;
      req_data_type = dt;
      do @(posedge clock); while (busy);
      model = resolve_request(kind, lo, hi, dt);
      expected_q.push_back(typed ? want : model);
   endtask

   always @(posedge clock) begin
      lookup_result_type exp_r;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_q.size() == 0) begin
            $error("response word with none expected");
            fail_count++;
         end else begin
            exp_r = expected_q.pop_front();
            if (rsp_status !== exp_r.status) begin
               $error("status: expected %0d, actual %0d", exp_r.status, rsp_status);
               fail_count++;
            end
            if (rsp_found_scope !== exp_r.scope) begin
               $error("found_scope: expected %0d, actual %0d", exp_r.scope, rsp_found_scope);
               fail_count++;
            end
            if (rsp_found_slot !== exp_r.slot) begin
               $error("found_slot: expected %0d, actual %0d", exp_r.slot, rsp_found_slot);
               fail_count++;
            end
            if (rsp_found_type !== exp_r.dtype) begin
               $error("found_type: expected %0d, actual %0d", exp_r.dtype, rsp_found_type);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #20000000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      logic [NAME_W-1:0] pool_name [12];
      int                pool_len  [12];
      logic [NAME_W-1:0] nm;
      logic [63:0]       lo;
      req_kind_type      kind;
      int                pick;
      int                sel;
      int                p;

      reset         = 1'b1;
      start         = 1'b0;
      req_type      = REQ_PUSH;
      req_name_lo   = '0;
      req_name_hi   = '0;
      req_data_type = '0;
      fail_count    = 0;
      steady        = 1'b0;
      sym_count     = 0;
      cur_depth     = 0;
      foreach (scope_base[i]) scope_base[i] = 0;
      foreach (sym_name[i]) begin
         sym_name[i]  = '0;
         sym_type[i]  = '0;
         sym_scope[i] = '0;
      end

      //   kind      name_lo                  name_hi                 dt  reps typed want
      row(REQ_POP,  64'h0,                   64'h0,                  0,  1,   1, STAT_UNDERFLOW, 0, 0, 0);
      row(REQ_FIND, 64'h6261,                64'h0,                  0,  1,   1, STAT_NOT_FOUND, 0, 0, 0);
      row(REQ_ADD,  64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 15, 1,  1, STAT_OK, 0, 0, 15);
      row(REQ_ADD,  64'h5A5A_5A5A_5A00_6261, 64'hFFFF_FFFF_FFFF_FFFF, 0,  1,   1, STAT_OK, 0, 1, 0);
      row(REQ_ADD,  64'h0,                   64'h0,                  3,  1,   1, STAT_OK, 0, 2, 3);
      row(REQ_ADD,  64'h6261,                64'h0,                  7,  1,   1, STAT_REDECLARED, 0, 1, 0);
      row(REQ_FIND, 64'hFFFF_FFFF_FFFF_FF00, 64'hFFFF_FFFF_FFFF_FFFF, 0,  1,  1, STAT_OK, 0, 2, 3);
      row(REQ_PUSH, 64'h0,                   64'h0,                  0,  1,   1, STAT_OK, 1, 0, 0);
      row(REQ_ADD,  64'h6261,                64'h0,                  9,  1,   1, STAT_OK, 1, 0, 9);
      row(REQ_FIND, 64'h6261,                64'h0,                  0,  1,   1, STAT_OK, 1, 0, 9);
      row(REQ_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0,  1,  1, STAT_OK, 0, 0, 15);
      row(REQ_ADD,  64'h7100,                64'h0,                  5,  127, 0, STAT_OK, 0, 0, 0);
      row(REQ_ADD,  64'h7A7A,                64'h0,                  1,  1,   1, STAT_FULL, 0, 0, 0);
      row(REQ_PUSH, 64'h0,                   64'h0,                  0,  1,   1, STAT_OK, 2, 0, 0);
      row(REQ_ADD,  64'h7200,                64'h0,                  6,  125, 0, STAT_OK, 0, 0, 0);
      row(REQ_ADD,  64'h7A7A,                64'h0,                  1,  1,   1, STAT_FULL, 0, 0, 0);
      row(REQ_FIND, 64'h717F,                64'h0,                  0,  1,   1, STAT_OK, 1, 127, 5);
      row(REQ_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0,  1,  1, STAT_OK, 0, 0, 15);
      row(REQ_POP,  64'h0,                   64'h0,                  0,  1,   1, STAT_OK, 1, 0, 0);
      row(REQ_POP,  64'h0,                   64'h0,                  0,  1,   1, STAT_OK, 0, 0, 0);
      row(REQ_PUSH, 64'h0,                   64'h0,                  0,  15,  0, STAT_OK, 0, 0, 0);
      row(REQ_FIND, 64'h6261,                64'h0,                  0,  1,   1, STAT_OK, 0, 1, 0);
      row(REQ_PUSH, 64'h0,                   64'h0,                  0,  1,   1, STAT_OVERFLOW, 15, 0, 0);
      row(REQ_POP,  64'h0,                   64'h0,                  0,  15,  0, STAT_OK, 0, 0, 0);
      row(REQ_POP,  64'h0,                   64'h0,                  0,  1,   1, STAT_UNDERFLOW, 0, 0, 0);

      for (int i = 0; i < 12; i++) begin
         pool_len[i]  = $urandom_range(1, 16);
         pool_name[i] = random_name(pool_len[i]);
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (script[r]) begin
         for (int k = 0; k < script[r].reps; k++) begin
            lo = script[r].lo;
            if (script[r].reps > 1) lo[7:0] = 8'(k + 1);
            send_word(script[r].kind, lo, script[r].hi, script[r].dt,
                      script[r].typed, script[r].want);
         end
      end

      for (int n = 0; n < 500; n++) begin
         steady = (n >= 200 && n < 380);
         pick   = $urandom_range(0, 99);
         kind   = pick < 12 ? REQ_PUSH : pick < 22 ? REQ_POP : pick < 62 ? REQ_FIND : REQ_ADD;
         sel    = $urandom_range(0, 99);
         p      = $urandom_range(0, 11);
         if (sel < 45) begin
            nm = pool_name[p];
         end else if (sel < 60) begin
            // same name, junk after the terminator
            nm = pool_name[p];
            for (int b = pool_len[p] + 1; b < 16; b++) nm[b*8 +: 8] = 8'($urandom_range(0, 255));
         end else if (sel < 90) begin
            nm = random_name($urandom_range(1, 16));
         end else begin
            nm = {$urandom, $urandom, $urandom, $urandom};
         end
         send_word(kind, nm[63:0], nm[127:64], DTYPE_W'($urandom_range(0, 15)), 1'b0, '0);
      end
      steady = 1'b0;

      @(negedge clock);
      start = 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+src
src/ssym_pkg.sv
src/ssym_ram.sv
src/ssym_scan.sv
src/scoped_symbol_table_top.sv
tb/scoped_symbol_table_top_test.sv
